@@ sv/ard_pkg.sv @@
// Shared types and constants for the AT response deframer.
// Used by ard_core, at_response_deframer and the testbench; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ard_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 256;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] STATUS_UP   = 8'h34;
    localparam logic [7:0] STATUS_DOWN = 8'h31;

    localparam int HEADER_KEEP   = 10;
    localparam int HDR_IDX_W     = 4;
    localparam int TAG_LEN       = 8;
    localparam int STATUS_OFFSET = 9;

    // "+BTSTATE"
    localparam logic [7:0] STATE_TAG [TAG_LEN] = '{
        8'h2B, 8'h42, 8'h54, 8'h53, 8'h54, 8'h41, 8'h54, 8'h45
    };

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       frame_done;
        logic       connect_event;
        logic       disconnect_event;
        logic       link_connected;
    } ard_result_t;

endpackage

`default_nettype wire

@@ sv/at_response_deframer.sv @@
// AT response deframer, top level: input register, decode core, result register.
// Depends on ard_pkg and ard_core.
//
// Usage:
//   Input channel in_valid/in_ready carries rx_byte, one received serial byte
//   per transfer. Output channel out_valid/out_ready carries one result per
//   byte: data_valid/data_byte for plain data, frame_done with connect_event
//   or disconnect_event when a CR LF framed response closes, and the current
//   link_connected flag.
//   The input register and then the result register carry each byte; a byte
//   waits in the input register while the result register is stalled.
//   Throughput: one byte per cycle while out_ready is high; the decode of each
//   byte against the framing flags and the ten kept header bytes is combinational.
//   Reset (rst_n low) clears the framing flags, write position, kept header
//   and connected flag; both pipeline stages come out empty.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more byte, then in_ready drops until out_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module at_response_deframer
    import ard_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            data_valid,
    output logic [7:0]      data_byte,
    output logic            frame_done,
    output logic            connect_event,
    output logic            disconnect_event,
    output logic            link_connected
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    ard_result_t res_reg;
    ard_result_t res_next;
    logic        s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    ard_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance),
        .rx_byte (s1_byte_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
        if (s1_advance)
            res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign data_valid       = res_reg.data_valid;
    assign data_byte        = res_reg.data_byte;
    assign frame_done       = res_reg.frame_done;
    assign connect_event    = res_reg.connect_event;
    assign disconnect_event = res_reg.disconnect_event;
    assign link_connected   = res_reg.link_connected;

`ifndef SYNTHESIS
    a_event_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (connect_event || disconnect_event) |-> frame_done)
        else $error("link event without frame close");

    a_event_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && connect_event |-> link_connected && !disconnect_event)
        else $error("connect event did not set link flag");

    a_data_not_framing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> !frame_done)
        else $error("data byte also flagged as frame close");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("decoded byte lost between stages");
`endif

endmodule

`default_nettype wire

@@ sv/ard_core.sv @@
// Framing state and per-byte decode for the AT response deframer.
// Depends on ard_pkg; state advances only when step is high.
`timescale 1ns / 1ps
`default_nettype none

module ard_core
    import ard_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    output ard_result_t      result
);

    localparam int WP_W = $clog2(BUFFER_DEPTH);

    logic            in_frame_reg, in_frame_next;
    logic            open_cr_reg, open_cr_next;
    logic            close_cr_reg, close_cr_next;
    logic [WP_W-1:0] wp_reg, wp_next;
    logic            connected_reg, connected_next;
    logic [7:0]      header_reg [HEADER_KEEP];
    logic            hdr_we;
    logic            tag_hit;

    always_comb
    begin
        tag_hit = 1'b1;
        for (int i = 0; i < TAG_LEN; i++)
        begin
            if (header_reg[i] != STATE_TAG[i])
                tag_hit = 1'b0;
        end
    end

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        open_cr_next   = open_cr_reg;
        close_cr_next  = close_cr_reg;
        wp_next        = wp_reg;
        connected_next = connected_reg;
        hdr_we         = 1'b0;
        result         = '0;

        if (!in_frame_reg)
        begin
            if (rx_byte == CHAR_CR)
                open_cr_next = 1'b1;
            else if (open_cr_reg)
            begin
                if (rx_byte == CHAR_LF)
                    in_frame_next = 1'b1;
                else
                    open_cr_next = 1'b0;
            end
            else
            begin
                result.data_valid = 1'b1;
                result.data_byte  = rx_byte;
            end
        end
        else
        begin
            if (rx_byte == CHAR_CR)
                close_cr_next = 1'b1;
            else if (close_cr_reg)
            begin
                if (rx_byte == CHAR_LF)
                begin
                    in_frame_next     = 1'b0;
                    open_cr_next      = 1'b0;
                    close_cr_next     = 1'b0;
                    wp_next           = '0;
                    result.frame_done = 1'b1;
                    if (tag_hit)
                    begin
                        if (header_reg[STATUS_OFFSET] == STATUS_UP)
                        begin
                            connected_next       = 1'b1;
                            result.connect_event = 1'b1;
                        end
                        else if (header_reg[STATUS_OFFSET] == STATUS_DOWN)
                        begin
                            connected_next          = 1'b0;
                            result.disconnect_event = 1'b1;
                        end
                    end
                end
                else
                    close_cr_next = 1'b0;
            end
            else
            begin
                hdr_we = (wp_reg < WP_W'(HEADER_KEEP));
                // wrap at the buffer depth
                if (wp_reg == WP_W'(BUFFER_DEPTH - 1))
                    wp_next = '0;
                else
                    wp_next = wp_reg + WP_W'(1);
            end
        end

        result.link_connected = connected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            open_cr_reg   <= 1'b0;
            close_cr_reg  <= 1'b0;
            wp_reg        <= '0;
            connected_reg <= 1'b0;
            for (int i = 0; i < HEADER_KEEP; i++)
                header_reg[i] <= '0;
        end
        else if (step)
        begin
            in_frame_reg  <= in_frame_next;
            open_cr_reg   <= open_cr_next;
            close_cr_reg  <= close_cr_next;
            wp_reg        <= wp_next;
            connected_reg <= connected_next;
            if (hdr_we)
                header_reg[wp_reg[HDR_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for at_response_deframer: directed and random byte streams,
// with an in-bench predictor of the framing, header match and connected flag.
// Depends on ard_pkg and the at_response_deframer RTL.
`timescale 1ns / 1ps

module testbench;
    import ard_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int BODY_WRAP   = BUFFER_DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 1000;
    localparam int TOTAL_BYTES = 2000;
    localparam int CALM_BYTES  = 300;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_ready = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic       connect_event;
    logic       disconnect_event;
    logic       link_connected;

    always #5 clk = ~clk;

    at_response_deframer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_valid       (data_valid),
        .data_byte        (data_byte),
        .frame_done       (frame_done),
        .connect_event    (connect_event),
        .disconnect_event (disconnect_event),
        .link_connected   (link_connected)
    );

    // Deframer state as the predictor tracks it, at reset values.
    logic       fr_open         = 1'b0;
    logic       cr_before_open  = 1'b0;
    logic       cr_before_close = 1'b0;
    int         body_pos        = 0;
    logic [7:0] hdr_kept [HEADER_KEEP] = '{default: 8'h00};
    logic       link_up         = 1'b0;

    ard_result_t pending_results [$];
    int          fault_count = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;

    function automatic ard_result_t deframe_byte(input logic [7:0] b);
        ard_result_t r;
        logic        tag_ok;
        r = '0;
        if (!fr_open)
        begin
            if (b == CHAR_CR)
                cr_before_open = 1'b1;
            else if (cr_before_open)
            begin
                // LF opens the frame; anything else is dropped
                if (b == CHAR_LF)
                    fr_open = 1'b1;
                else
                    cr_before_open = 1'b0;
            end
            else
            begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
            end
        end
        else
        begin
            if (b == CHAR_CR)
                cr_before_close = 1'b1;
            else if (cr_before_close)
            begin
                if (b == CHAR_LF)
                begin
                    fr_open         = 1'b0;
                    cr_before_open  = 1'b0;
                    cr_before_close = 1'b0;
                    body_pos        = 0;
                    r.frame_done    = 1'b1;
                    tag_ok          = 1'b1;
                    for (int i = 0; i < TAG_LEN; i++)
                        if (hdr_kept[i] != STATE_TAG[i])
                            tag_ok = 1'b0;
                    if (tag_ok && hdr_kept[STATUS_OFFSET] == STATUS_UP)
                    begin
                        link_up         = 1'b1;
                        r.connect_event = 1'b1;
                    end
                    else if (tag_ok && hdr_kept[STATUS_OFFSET] == STATUS_DOWN)
                    begin
                        link_up            = 1'b0;
                        r.disconnect_event = 1'b1;
                    end
                end
                else
                    cr_before_close = 1'b0;
            end
            else
            begin
                if (body_pos < HEADER_KEEP)
                    hdr_kept[body_pos] = b;
                body_pos++;
                if (body_pos >= BUFFER_DEPTH_DEFAULT)
                    body_pos = 0;
            end
        end
        r.link_connected = link_up;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ard_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: data_byte 0x%02h", data_byte);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
                check_field("data_byte", want.data_byte, data_byte);
                check_field("frame_done", 8'(want.frame_done), 8'(frame_done));
                check_field("connect_event", 8'(want.connect_event), 8'(connect_event));
                check_field("disconnect_event", 8'(want.disconnect_event),
                            8'(disconnect_event));
                check_field("link_connected", 8'(want.link_connected), 8'(link_connected));
            end
        end
    end

    // End the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("at_response_deframer: mismatch");
                $finish;
            end
        end
    end

    always
    begin : receiver_stall
        @(negedge clk);
        if (rst_n && !calm && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    // Enter and leave at a falling edge; valid stays high for a following byte.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 15) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(deframe_byte(b));
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
        return b;
    endfunction

    task automatic append_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    task automatic send_frame(input byte_q_t body);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // Body long enough to wrap the write position and overwrite the kept header.
    task automatic send_wrap_frame(input logic [7:0] first_status, input logic [7:0] last_status);
        byte_q_t body;
        append_text(body, "+BTSTATE:");
        body.push_back(first_status);
        while (body.size() < BODY_WRAP)
            body.push_back(body_byte());
        append_text(body, "+BTSTATE:");
        body.push_back(last_status);
        repeat ($urandom_range(0, 5)) body.push_back(body_byte());
        send_frame(body);
    endtask

    task automatic send_state_frame();
        byte_q_t    body;
        logic [7:0] noise;
        int         idx;
        append_text(body, "+BTSTATE:");
        case ($urandom_range(0, 2))
            0: body.push_back(STATUS_UP);
            1: body.push_back(STATUS_DOWN);
            default: body.push_back(body_byte());
        endcase
        if ($urandom_range(0, 3) == 0)
            body[$urandom_range(0, HEADER_KEEP - 1)] = body_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            // truncate: the header compare then sees stale bytes
            idx = $urandom_range(0, HEADER_KEEP - 1);
            while (body.size() > idx)
                void'(body.pop_back());
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) body.push_back(body_byte());
        if ($urandom_range(0, 5) == 0)
        begin
            // CR then a byte that is neither CR nor LF: both dropped
            do noise = 8'($urandom_range(0, 255)); while (noise == CHAR_CR || noise == CHAR_LF);
            idx = $urandom_range(0, body.size());
            body.insert(idx, noise);
            body.insert(idx, CHAR_CR);
        end
        send_frame(body);
    endtask

    task automatic send_noise();
        int pick;
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(0, 5);
            if (pick < 2)
                send_byte(CHAR_CR);
            else if (pick == 2)
                send_byte(CHAR_LF);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_byte(8'h55);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(8'hAA);
        send_byte(8'h33);
        wait_drained();
    endtask

    task automatic test_state_frames();
        byte_q_t body;
        append_text(body, "+BTSTATE:4");
        send_frame(body);
        body.delete();
        send_frame(body);
        append_text(body, "+BT");
        body.push_back(CHAR_CR);
        body.push_back("Z");
        append_text(body, "STATE:1");
        send_frame(body);
        body.delete();
        append_text(body, "+BTSTATE:7");
        send_frame(body);
        body.delete();
        append_text(body, "+BTSTATX:4");
        send_frame(body);
        wait_drained();
    endtask

    task automatic test_header_wrap();
        send_wrap_frame(STATUS_DOWN, STATUS_UP);
        send_wrap_frame(STATUS_UP, STATUS_DOWN);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int target);
        byte_q_t body;
        int      sel;
        while (bytes_sent < target)
        begin
            sel = $urandom_range(0, 39);
            if (sel < 16)
                send_state_frame();
            else if (sel < 26)
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            else if (sel < 32)
            begin
                body.delete();
                repeat ($urandom_range(0, 12)) body.push_back(body_byte());
                send_frame(body);
            end
            else if (sel < 38)
                send_noise();
            else if (sel == 38)
                wait_drained();
            else if ($urandom_range(0, 2) == 0)
                send_wrap_frame(body_byte(), $urandom_range(0, 1) ? STATUS_UP : STATUS_DOWN);
        end
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        test_random_traffic(bytes_sent + CALM_BYTES);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_plain_bytes();
        test_state_frames();
        test_header_wrap();
        test_random_traffic(TOTAL_BYTES - CALM_BYTES);
        test_steady_stream();
        wait_drained();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("at_response_deframer: match");
        else
            $display("at_response_deframer: mismatch");
        $finish;
    end

endmodule
